// ===== design/mra_pkg.sv =====
`timescale 1ns / 1ps

package mra_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int ACC_W       = 16;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 16'sh7FFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 16'sh8000;

	typedef enum logic [2:0] {
		KIND_BUTTON  = 3'd0,
		KIND_MOVE    = 3'd1,
		KIND_WHEEL   = 3'd2,
		KIND_CONSUME = 3'd3,
		KIND_RELEASE = 3'd4,
		KIND_CLEAR   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		BTN_LEFT     = 3'd0,
		BTN_RIGHT    = 3'd1,
		BTN_MIDDLE   = 3'd2,
		BTN_FORWARD  = 3'd3,
		BTN_BACKWARD = 3'd4
	} button_t;

	typedef struct packed {
		logic add;
		logic take;
	} lane_ctl_t;

endpackage

// ===== design/mra_evt_if.sv =====
`timescale 1ns / 1ps

interface mra_evt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [2:0]         button_code;
	logic               pressed;
	logic signed [15:0] delta_x;
	logic signed [15:0] delta_y;
	logic signed [15:0] delta_wheel;
	logic signed [15:0] delta_pan;

	modport source (
		output valid, kind, button_code, pressed, delta_x, delta_y, delta_wheel, delta_pan,
		input  ready
	);

	modport sink (
		input  valid, kind, button_code, pressed, delta_x, delta_y, delta_wheel, delta_pan,
		output ready
	);
endinterface

// ===== design/mra_rpt_if.sv =====
`timescale 1ns / 1ps

interface mra_rpt_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic [4:0]         button_mask;
	logic signed [15:0] pending_x;
	logic signed [15:0] pending_y;
	logic signed [15:0] pending_wheel;
	logic signed [15:0] pending_pan;

	modport source (
		output valid, ok, button_mask, pending_x, pending_y, pending_wheel, pending_pan,
		input  ready
	);

	modport sink (
		input  valid, ok, button_mask, pending_x, pending_y, pending_wheel, pending_pan,
		output ready
	);
endinterface

// ===== design/mra_lane.sv =====
`timescale 1ns / 1ps

module mra_lane
	import mra_pkg::*;
(
	input  logic signed [ACC_W-1:0] acc,
	input  logic signed [ACC_W-1:0] delta,
	input  lane_ctl_t               ctl,
	output logic signed [ACC_W-1:0] acc_next,
	output logic                    ok
);

	logic signed [ACC_W:0] ext_acc;
	logic signed [ACC_W:0] ext_delta;
	logic signed [ACC_W:0] sum;
	logic signed [ACC_W:0] neg_acc;
	logic signed [ACC_W:0] neg_delta;
	logic        [ACC_W:0] mag_acc;
	logic        [ACC_W:0] mag_delta;
	logic                  take_fail;

	assign ext_acc   = {acc[ACC_W-1], acc};
	assign ext_delta = {delta[ACC_W-1], delta};
	assign sum       = ext_acc + ext_delta;
	assign neg_acc   = -ext_acc;
	assign neg_delta = -ext_delta;
	assign mag_acc   = acc[ACC_W-1] ? neg_acc : ext_acc;
	assign mag_delta = delta[ACC_W-1] ? neg_delta : ext_delta;

	// nonzero amount needs same-signed pending value of no smaller magnitude
	assign take_fail = (delta != '0) &&
		((acc == '0) || (acc[ACC_W-1] != delta[ACC_W-1]) || (mag_acc < mag_delta));

	always_comb begin
		acc_next = acc;
		ok       = 1'b1;
		if (ctl.add) begin
			if (sum > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) begin
				acc_next = ACC_MAX;
			end else if (sum < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) begin
				acc_next = ACC_MIN;
			end else begin
				acc_next = sum[ACC_W-1:0];
			end
		end else if (ctl.take) begin
			ok = !take_fail;
			if (!take_fail) begin
				acc_next = acc - delta;
			end
		end
	end

endmodule

// ===== design/mouse_report_accumulator.sv =====
`timescale 1ns / 1ps

// Mouse report accumulator. Each event transaction on evt (button, move, wheel,
// consume, release all, clear) updates the pending report and yields exactly one
// report transaction on rpt holding ok and the button mask and x, y, wheel and pan
// accumulators after the event. An event is registered on acceptance and resolved,
// once the report register is free or being taken, against the held report by one
// pass of saturating add or conditional subtract per axis, then held in the report
// register and offered on rpt; one event is taken every cycle while rpt keeps up.
// Consume works through x, y, wheel, pan and stops at the first axis that fails,
// leaving earlier axes reduced.

module mouse_report_accumulator
	import mra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mra_evt_if.sink     evt,
	mra_rpt_if.source   rpt
);

	logic                   valid_s1;
	logic [2:0]             kind_s1;
	logic [2:0]             button_code_s1;
	logic                   pressed_s1;
	logic signed [ACC_W-1:0] delta_x_s1;
	logic signed [ACC_W-1:0] delta_y_s1;
	logic signed [ACC_W-1:0] delta_wheel_s1;
	logic signed [ACC_W-1:0] delta_pan_s1;

	logic [NUM_BUTTONS-1:0] buttons_q;
	logic signed [ACC_W-1:0] acc_x_q;
	logic signed [ACC_W-1:0] acc_y_q;
	logic signed [ACC_W-1:0] acc_wheel_q;
	logic signed [ACC_W-1:0] acc_pan_q;

	logic                   valid_s2;
	logic                   ok_s2;

	logic                   advance;

	lane_ctl_t              ctl_x;
	lane_ctl_t              ctl_y;
	lane_ctl_t              ctl_wheel;
	lane_ctl_t              ctl_pan;
	logic signed [ACC_W-1:0] x_next;
	logic signed [ACC_W-1:0] y_next;
	logic signed [ACC_W-1:0] wheel_next;
	logic signed [ACC_W-1:0] pan_next;
	logic                   ok_x;
	logic                   ok_y;
	logic                   ok_wheel;
	logic                   ok_pan;

	logic [NUM_BUTTONS-1:0] buttons_d;
	logic signed [ACC_W-1:0] acc_x_d;
	logic signed [ACC_W-1:0] acc_y_d;
	logic signed [ACC_W-1:0] acc_wheel_d;
	logic signed [ACC_W-1:0] acc_pan_d;
	logic                   ok_d;
	logic                   is_move;
	logic                   is_wheel;
	logic                   is_consume;

	assign advance   = valid_s1 && (!valid_s2 || rpt.ready);
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1        <= evt.kind;
			button_code_s1 <= evt.button_code;
			pressed_s1     <= evt.pressed;
			delta_x_s1     <= evt.delta_x;
			delta_y_s1     <= evt.delta_y;
			delta_wheel_s1 <= evt.delta_wheel;
			delta_pan_s1   <= evt.delta_pan;
		end
	end

	assign is_move    = (kind_t'(kind_s1) == KIND_MOVE);
	assign is_wheel   = (kind_t'(kind_s1) == KIND_WHEEL);
	assign is_consume = (kind_t'(kind_s1) == KIND_CONSUME);

	// consume chain: each axis is tried only when the one before it passed
	assign ctl_x     = '{add: is_move,  take: is_consume};
	assign ctl_y     = '{add: is_move,  take: is_consume && ok_x};
	assign ctl_wheel = '{add: is_wheel, take: is_consume && ok_x && ok_y};
	assign ctl_pan   = '{add: is_wheel, take: is_consume && ok_x && ok_y && ok_wheel};

	mra_lane u_lane_x (
		.acc(acc_x_q), .delta(delta_x_s1), .ctl(ctl_x), .acc_next(x_next), .ok(ok_x)
	);
	mra_lane u_lane_y (
		.acc(acc_y_q), .delta(delta_y_s1), .ctl(ctl_y), .acc_next(y_next), .ok(ok_y)
	);
	mra_lane u_lane_wheel (
		.acc(acc_wheel_q), .delta(delta_wheel_s1), .ctl(ctl_wheel),
		.acc_next(wheel_next), .ok(ok_wheel)
	);
	mra_lane u_lane_pan (
		.acc(acc_pan_q), .delta(delta_pan_s1), .ctl(ctl_pan),
		.acc_next(pan_next), .ok(ok_pan)
	);

	always_comb begin
		buttons_d   = buttons_q;
		acc_x_d     = x_next;
		acc_y_d     = y_next;
		acc_wheel_d = wheel_next;
		acc_pan_d   = pan_next;
		ok_d        = 1'b0;
		case (kind_t'(kind_s1))
			KIND_BUTTON: begin
				if (button_code_s1 inside {[BTN_LEFT:BTN_BACKWARD]}) begin
					buttons_d[button_code_s1] = pressed_s1;
					ok_d = 1'b1;
				end
			end
			KIND_MOVE, KIND_WHEEL: begin
				ok_d = 1'b1;
			end
			KIND_CONSUME: begin
				ok_d = ok_x && ok_y && ok_wheel && ok_pan;
			end
			KIND_RELEASE: begin
				buttons_d = '0;
				ok_d      = 1'b1;
			end
			KIND_CLEAR: begin
				buttons_d   = '0;
				acc_x_d     = '0;
				acc_y_d     = '0;
				acc_wheel_d = '0;
				acc_pan_d   = '0;
				ok_d        = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buttons_q   <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_wheel_q <= '0;
			acc_pan_q   <= '0;
		end else if (advance) begin
			buttons_q   <= buttons_d;
			acc_x_q     <= acc_x_d;
			acc_y_q     <= acc_y_d;
			acc_wheel_q <= acc_wheel_d;
			acc_pan_q   <= acc_pan_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rpt.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s2 <= ok_d;
		end
	end

	// report mirrors the state registers, which only move with a new report
	assign rpt.valid         = valid_s2;
	assign rpt.ok            = ok_s2;
	assign rpt.button_mask   = buttons_q;
	assign rpt.pending_x     = acc_x_q;
	assign rpt.pending_y     = acc_y_q;
	assign rpt.pending_wheel = acc_wheel_q;
	assign rpt.pending_pan   = acc_pan_q;

	a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(acc_x_q) && $stable(acc_pan_q) && $stable(buttons_q))
		else $error("report state changed without an event");

	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 == KIND_CLEAR) |=>
			(buttons_q == '0) && (acc_x_q == '0) && (acc_y_q == '0) &&
			(acc_wheel_q == '0) && (acc_pan_q == '0) && ok_s2)
		else $error("clear did not zero the report");

	a_rejected_kind: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (kind_s1 > KIND_CLEAR) |=>
			!ok_s2 && $stable(buttons_q) && $stable(acc_y_q) && $stable(acc_wheel_q))
		else $error("rejected event changed the report");

endmodule

// ===== test/tb_mouse_report_accumulator.sv =====
`timescale 1ns / 1ps

module tb_mouse_report_accumulator;
	import mra_pkg::*;

	localparam logic [2:0] KIND_BAD_FIRST = 3'd6;
	localparam logic [2:0] KIND_BAD_LAST  = 3'd7;
	localparam logic [2:0] BTN_BAD_FIRST  = 3'd5;
	localparam logic [2:0] BTN_BAD_LAST   = 3'd7;
	localparam int RANDOM_PER_PHASE = 475;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int MAX_REPORTED     = 10;

	typedef struct {
		logic [2:0]         kind;
		logic [2:0]         code;
		logic               pressed;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dw;
		logic signed [15:0] dp;
	} mouse_event_t;

	typedef struct packed {
		logic               ok;
		logic [4:0]         mask;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] wheel;
		logic signed [15:0] pan;
	} report_t;

	logic clk;
	logic arst_n;

	mra_evt_if evt_bus ();
	mra_rpt_if rpt_bus ();

	mouse_report_accumulator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_bus),
		.rpt    (rpt_bus)
	);

	mouse_event_t event_queue[$];
	report_t      expected_reports[$];
	report_t      report_model;
	report_t      stim_state;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           mismatches;
	int           cycle_count;
	bit           evt_taken;

	always #1 clk = ~clk;

	function automatic logic signed [15:0] sat_add(logic signed [15:0] a, logic signed [15:0] b);
		int s;
		s = a;
		s = s + b;
		if (s > int'(ACC_MAX)) return ACC_MAX;
		if (s < int'(ACC_MIN)) return ACC_MIN;
		return s[15:0];
	endfunction

	function automatic bit can_take(logic signed [15:0] acc, logic signed [15:0] amt);
		int mp;
		int ma;
		if (amt == 0) return 1;
		if (acc == 0) return 0;
		if (acc[15] != amt[15]) return 0;
		mp = acc;
		ma = amt;
		if (mp < 0) mp = -mp;
		if (ma < 0) ma = -ma;
		return mp >= ma;
	endfunction

	function automatic report_t next_report(report_t cur, mouse_event_t ev);
		report_t            nxt;
		logic signed [15:0] acc[4];
		logic signed [15:0] amt[4];
		nxt = cur;
		nxt.ok = 1'b0;
		case (ev.kind)
			KIND_BUTTON: begin
				if (ev.code <= BTN_BACKWARD) begin
					nxt.mask[ev.code] = ev.pressed;
					nxt.ok = 1'b1;
				end
			end
			KIND_MOVE: begin
				nxt.x = sat_add(cur.x, ev.dx);
				nxt.y = sat_add(cur.y, ev.dy);
				nxt.ok = 1'b1;
			end
			KIND_WHEEL: begin
				nxt.wheel = sat_add(cur.wheel, ev.dw);
				nxt.pan = sat_add(cur.pan, ev.dp);
				nxt.ok = 1'b1;
			end
			KIND_CONSUME: begin
				acc[0] = cur.x;
				acc[1] = cur.y;
				acc[2] = cur.wheel;
				acc[3] = cur.pan;
				amt[0] = ev.dx;
				amt[1] = ev.dy;
				amt[2] = ev.dw;
				amt[3] = ev.dp;
				nxt.ok = 1'b1;
				for (int i = 0; i < 4; i++) begin
					if (nxt.ok) begin
						if (can_take(acc[i], amt[i])) acc[i] = acc[i] - amt[i];
						else nxt.ok = 1'b0;
					end
				end
				nxt.x = acc[0];
				nxt.y = acc[1];
				nxt.wheel = acc[2];
				nxt.pan = acc[3];
			end
			KIND_RELEASE: begin
				nxt.mask = '0;
				nxt.ok = 1'b1;
			end
			KIND_CLEAR: begin
				nxt = '0;
				nxt.ok = 1'b1;
			end
			default: nxt.ok = 1'b0;
		endcase
		return nxt;
	endfunction

	task automatic push_event(mouse_event_t ev);
		event_queue.push_back(ev);
		stim_state = next_report(stim_state, ev);
	endtask

	task automatic queue_event(logic [2:0] kind, logic [2:0] code, logic pressed,
			int dx, int dy, int dw, int dp);
		mouse_event_t ev;
		ev.kind = kind;
		ev.code = code;
		ev.pressed = pressed;
		ev.dx = dx[15:0];
		ev.dy = dy[15:0];
		ev.dw = dw[15:0];
		ev.dp = dp[15:0];
		push_event(ev);
	endtask

	function automatic logic signed [15:0] random_delta();
		int v;
		if ($urandom_range(9) < 7) begin
			v = $urandom_range(0, 400);
			v = v - 200;
			return v[15:0];
		end
		return 16'($urandom);
	endfunction

	function automatic logic signed [15:0] consume_amount(logic signed [15:0] pend);
		int pv;
		int amt;
		int r;
		pv = pend;
		r = $urandom_range(9);
		if (r < 2) return '0;
		if (r < 4) return pend;
		if (r < 8) begin
			if (pv == 0) begin
				amt = $urandom_range(1, 5);
				if ($urandom_range(1)) amt = -amt;
			end else begin
				amt = $urandom_range(1, (pv < 0) ? -pv : pv);
				if (pv < 0) amt = -amt;
			end
			return amt[15:0];
		end
		if (r == 8) return 16'($urandom);
		amt = (pv >= 0) ? pv + 1 : pv - 1;
		return amt[15:0];
	endfunction

	task automatic queue_random_event();
		mouse_event_t ev;
		int sel;
		ev.kind = 3'($urandom);
		ev.code = 3'($urandom);
		ev.pressed = 1'($urandom);
		ev.dx = 16'($urandom);
		ev.dy = 16'($urandom);
		ev.dw = 16'($urandom);
		ev.dp = 16'($urandom);
		sel = $urandom_range(99);
		if (sel < 22) begin
			ev.kind = KIND_BUTTON;
			if ($urandom_range(9) < 9) ev.code = 3'($urandom_range(BTN_LEFT, BTN_BACKWARD));
			else ev.code = 3'($urandom_range(BTN_BAD_FIRST, BTN_BAD_LAST));
		end else if (sel < 45) begin
			ev.kind = KIND_MOVE;
			ev.dx = random_delta();
			ev.dy = random_delta();
		end else if (sel < 60) begin
			ev.kind = KIND_WHEEL;
			ev.dw = random_delta();
			ev.dp = random_delta();
		end else if (sel < 88) begin
			ev.kind = KIND_CONSUME;
			ev.dx = consume_amount(stim_state.x);
			ev.dy = consume_amount(stim_state.y);
			ev.dw = consume_amount(stim_state.wheel);
			ev.dp = consume_amount(stim_state.pan);
		end else if (sel < 92) begin
			ev.kind = KIND_RELEASE;
		end else if (sel < 95) begin
			ev.kind = KIND_CLEAR;
		end else begin
			ev.kind = 3'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
		end
		push_event(ev);
	endtask

	task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTED)
			$display("mismatch on %s: expected %h, got %h", field, want, got);
	endtask

	// driver: event channel source and report channel ready
	always @(negedge clk) begin : drive_evt
		mouse_event_t ev;
		if (arst_n) begin
			if (!evt_bus.valid || evt_taken) begin
				if (event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					ev = event_queue.pop_front();
					evt_bus.valid <= 1'b1;
					evt_bus.kind <= ev.kind;
					evt_bus.button_code <= ev.code;
					evt_bus.pressed <= ev.pressed;
					evt_bus.delta_x <= ev.dx;
					evt_bus.delta_y <= ev.dy;
					evt_bus.delta_wheel <= ev.dw;
					evt_bus.delta_pan <= ev.dp;
				end else begin
					evt_bus.valid <= 1'b0;
				end
			end
			rpt_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: predict on each accepted event, check each report transaction
	always @(posedge clk) begin : watch_bus
		mouse_event_t ev;
		report_t      want;
		evt_taken = 1'b0;
		if (arst_n) begin
			if (evt_bus.valid && evt_bus.ready) begin
				evt_taken = 1'b1;
				ev.kind = evt_bus.kind;
				ev.code = evt_bus.button_code;
				ev.pressed = evt_bus.pressed;
				ev.dx = evt_bus.delta_x;
				ev.dy = evt_bus.delta_y;
				ev.dw = evt_bus.delta_wheel;
				ev.dp = evt_bus.delta_pan;
				report_model = next_report(report_model, ev);
				expected_reports.push_back(report_model);
			end
			if (rpt_bus.valid && rpt_bus.ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("report transaction with no expected report");
				end else begin
					want = expected_reports.pop_front();
					if (rpt_bus.ok !== want.ok) note_mismatch("ok", want.ok, rpt_bus.ok);
					if (rpt_bus.button_mask !== want.mask)
						note_mismatch("button_mask", want.mask, rpt_bus.button_mask);
					if (rpt_bus.pending_x !== want.x)
						note_mismatch("pending_x", want.x, rpt_bus.pending_x);
					if (rpt_bus.pending_y !== want.y)
						note_mismatch("pending_y", want.y, rpt_bus.pending_y);
					if (rpt_bus.pending_wheel !== want.wheel)
						note_mismatch("pending_wheel", want.wheel, rpt_bus.pending_wheel);
					if (rpt_bus.pending_pan !== want.pan)
						note_mismatch("pending_pan", want.pan, rpt_bus.pending_pan);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int idle_send[4];
		int idle_recv[4];
		idle_send = '{0, 52, 0, 29};
		idle_recv = '{0, 0, 52, 29};
		clk = 1'b0;
		arst_n = 1'b0;
		evt_bus.valid = 1'b0;
		evt_bus.kind = '0;
		evt_bus.button_code = '0;
		evt_bus.pressed = 1'b0;
		evt_bus.delta_x = '0;
		evt_bus.delta_y = '0;
		evt_bus.delta_wheel = '0;
		evt_bus.delta_pan = '0;
		rpt_bus.ready = 1'b0;
		report_model = '0;
		stim_state = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		cycle_count = 0;
		evt_taken = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: buttons, bad codes, saturation, consume rules
		queue_event(KIND_BUTTON, BTN_LEFT, 1'b1, 0, 0, 0, 0);
		queue_event(KIND_BUTTON, BTN_RIGHT, 1'b1, -1, -1, -1, -1);
		queue_event(KIND_BUTTON, BTN_MIDDLE, 1'b1, 32767, 32767, 32767, 32767);
		queue_event(KIND_BUTTON, BTN_FORWARD, 1'b1, -32768, -32768, -32768, -32768);
		queue_event(KIND_BUTTON, BTN_BACKWARD, 1'b1, 0, 0, 0, 0);
		queue_event(KIND_BUTTON, BTN_BAD_FIRST, 1'b1, 0, 0, 0, 0);
		queue_event(KIND_BUTTON, BTN_BAD_LAST, 1'b0, 0, 0, 0, 0);
		queue_event(KIND_BUTTON, BTN_BACKWARD, 1'b0, 0, 0, 0, 0);
		queue_event(KIND_MOVE, BTN_LEFT, 1'b0, 32767, -32768, 5, 5);
		queue_event(KIND_MOVE, BTN_LEFT, 1'b0, 1, -1, 0, 0);
		queue_event(KIND_WHEEL, BTN_LEFT, 1'b0, 7, 7, -32768, 32767);
		queue_event(KIND_WHEEL, BTN_LEFT, 1'b0, 0, 0, -5, 100);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, 0, 0, 0, 0);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, -1, 0, 0, 0);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, 32767, -32768, -32768, 32767);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, 1, 0, 0, 0);
		queue_event(KIND_MOVE, BTN_LEFT, 1'b0, 100, -50, 0, 0);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, 40, -60, 0, 0);
		queue_event(KIND_BAD_FIRST, BTN_LEFT, 1'b1, 10, 10, 10, 10);
		queue_event(KIND_BAD_LAST, BTN_RIGHT, 1'b1, 10, 10, 10, 10);
		queue_event(KIND_RELEASE, BTN_LEFT, 1'b0, 0, 0, 0, 0);
		queue_event(KIND_BUTTON, BTN_LEFT, 1'b1, 0, 0, 0, 0);
		queue_event(KIND_CLEAR, BTN_LEFT, 1'b0, 0, 0, 0, 0);
		queue_event(KIND_MOVE, BTN_LEFT, 1'b0, -32768, 32767, 0, 0);
		queue_event(KIND_CONSUME, BTN_LEFT, 1'b0, -32768, 0, 0, 0);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_send[phase];
			recv_stall_pct = idle_recv[phase];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_random_event();
			while (event_queue.size() != 0 || evt_bus.valid || expected_reports.size() != 0)
				@(posedge clk);
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/mra_pkg.sv
design/mra_evt_if.sv
design/mra_rpt_if.sv
design/mra_lane.sv
design/mouse_report_accumulator.sv
test/tb_mouse_report_accumulator.sv
